// ===== hdl/us3s_pkg.sv =====
// Shared types for the three-byte UTF-8 sanitizer.
`default_nettype none
package us3s_pkg;

    localparam int unsigned WinDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       ends_stream;
    } out_item_t;

    typedef logic [WinDepth-1:0][7:0] win_t;

    // Result of deciding the head byte of the window.
    typedef struct packed {
        logic [2:0][7:0] em;
        logic [1:0]      ne;
        logic [1:0]      used;
    } dec_res_t;

    // Sequencer to output stage.
    typedef struct packed {
        logic       push;
        logic       close;
        logic       ends;
        logic [7:0] data;
    } emit_ctl_t;

    localparam logic [7:0] ByteTab   = 8'h09;
    localparam logic [7:0] ByteLf    = 8'h0A;
    localparam logic [7:0] ByteCr    = 8'h0D;
    localparam logic [7:0] ByteEuro  = 8'h80;
    localparam logic [7:0] ByteNel   = 8'h85;
    localparam logic [7:0] EuroB0    = 8'hE2;
    localparam logic [7:0] EuroB1    = 8'h82;
    localparam logic [7:0] EuroB2    = 8'hAC;
    localparam logic [7:0] LeadC2    = 8'hC2;
    localparam logic [7:0] LeadC3    = 8'hC3;

endpackage
`default_nettype wire

// ===== hdl/utf8_three_byte_sanitizer.sv =====
// Top level: window, sequencer and shared decision unit of the UTF-8 sanitizer.
//
// Usage: raw bytes enter on in_valid/in_ready/in_data (data_byte, is_last) and
// cleaned UTF-8 leaves on out_valid/out_ready/out_data, one byte per
// transaction. Each byte is held in a four-byte window; once the window is
// full the head byte is decided, and an input with is_last set flushes the
// whole window. in_ready is high only while the sequencer is idle.
// Per input: the accept step, then (when the window is full or is_last is set)
// for each decision a step in the shared decision unit followed by one emit
// step per emitted byte, then a closing step; with nothing to decide, only the
// accept and closing steps. A flush takes up to 4 decisions. The first result
// passes through the decision, the hold stage and the output register; the
// last result of a transaction is marked by last_of_run.
// Reset empties the window and drops any pending output. If the receiver
// stalls, the output register and hold stage fill and the sequencer waits;
// no byte is lost.
`default_nettype none
module utf8_three_byte_sanitizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  us3s_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output us3s_pkg::out_item_t  out_data
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StDecide = 2'd1;
    localparam logic [1:0] StEmit   = 2'd2;
    localparam logic [1:0] StClose  = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    us3s_pkg::win_t      win_reg;
    us3s_pkg::win_t      win_next;
    logic [2:0]          count_reg;
    logic [2:0]          count_next;
    logic                last_reg;
    logic                last_next;
    logic [2:0][7:0]     em_reg;
    logic [2:0][7:0]     em_next;
    logic [1:0]          ne_reg;
    logic [1:0]          ne_next;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    us3s_pkg::dec_res_t  dec;
    us3s_pkg::emit_ctl_t ctl;
    logic                ctl_ok;
    logic [2:0]          fill;
    logic [2:0]          src;
    logic [2:0]          left;

    us3s_decide u_decide (
        .win   (win_reg),
        .count (count_reg),
        .res   (dec)
    );

    us3s_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ctl_ok    (ctl_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = (state_reg == StIdle);
    assign fill     = (count_reg == 3'd4) ? 3'd3 : count_reg;
    assign left     = count_reg - {1'b0, dec.used};

    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        count_next = count_reg;
        last_next  = last_reg;
        em_next    = em_reg;
        ne_next    = ne_reg;
        idx_next   = idx_reg;
        src        = 3'd0;
        ctl.push   = 1'b0;
        ctl.close  = 1'b0;
        ctl.ends   = last_reg;
        ctl.data   = em_reg[idx_reg];
        case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    win_next[fill[1:0]] = in_data.data_byte;
                    count_next          = fill + 3'd1;
                    last_next           = in_data.is_last;
                    if (in_data.is_last || fill == 3'd3)
                        state_next = StDecide;
                    else
                        state_next = StClose;
                end
            end
            StDecide:
            begin
                em_next    = dec.em;
                ne_next    = dec.ne;
                idx_next   = 2'd0;
                count_next = left;
                for (int i = 0; i < us3s_pkg::WinDepth; i++)
                begin
                    src = 3'(i) + {1'b0, dec.used};
                    win_next[i] = (src < 3'd4) ? win_reg[src[1:0]] : 8'd0;
                end
                if (dec.ne != 2'd0)
                    state_next = StEmit;
                else if (last_reg && left != 3'd0)
                    state_next = StDecide;
                else
                    state_next = StClose;
            end
            StEmit:
            begin
                ctl.push = 1'b1;
                if (ctl_ok)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == ne_reg - 2'd1)
                        state_next = (last_reg && count_reg != 3'd0) ? StDecide : StClose;
                end
            end
            StClose:
            begin
                ctl.close = 1'b1;
                if (ctl_ok)
                    state_next = StIdle;
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            win_reg   <= '0;
            count_reg <= 3'd0;
            last_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_reg <= em_next;
        ne_reg <= ne_next;
    end

endmodule
`default_nettype wire

// ===== hdl/us3s_decide.sv =====
// Head-byte decision unit: classifies the window head and its followers.
`default_nettype none
module us3s_decide (
    input  us3s_pkg::win_t     win,
    input  logic [2:0]         count,
    output us3s_pkg::dec_res_t res
);

    logic [7:0] c;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       cont1;
    logic       cont2;
    logic [2:0] nf;

    assign c     = win[0];
    assign b1    = win[1];
    assign b2    = win[2];
    assign cont1 = (b1[7:6] == 2'b10);
    assign cont2 = (b2[7:6] == 2'b10);
    assign nf    = count - 3'd1;

    always_comb
    begin
        res.em   = '0;
        res.ne   = 2'd0;
        res.used = 2'd1;
        if (c < 8'd32)
        begin
            res.em[0] = c;
            if (c == us3s_pkg::ByteTab || c == us3s_pkg::ByteLf || c == us3s_pkg::ByteCr)
                res.ne = 2'd1;
        end
        else if (c < 8'd127)
        begin
            res.em[0] = c;
            res.ne    = 2'd1;
        end
        else if (c < 8'd160)
        begin
            if (c == us3s_pkg::ByteEuro)
            begin
                res.em[0] = us3s_pkg::EuroB0;
                res.em[1] = us3s_pkg::EuroB1;
                res.em[2] = us3s_pkg::EuroB2;
                res.ne    = 2'd3;
            end
            else if (c == us3s_pkg::ByteNel)
            begin
                res.em[0] = us3s_pkg::ByteLf;
                res.em[1] = us3s_pkg::ByteCr;
                res.ne    = 2'd2;
            end
        end
        else if (c < 8'd192)
        begin
            res.em[0] = us3s_pkg::LeadC2;
            res.em[1] = c;
            res.ne    = 2'd2;
        end
        else if (c >= 8'd194 && c < 8'd224 && nf >= 3'd1 && cont1)
        begin
            res.em[0] = c;
            res.em[1] = b1;
            res.used  = 2'd2;
            // C2 encodings of C1 controls are dropped
            res.ne    = (c == us3s_pkg::LeadC2 && b1 < 8'd160) ? 2'd0 : 2'd2;
        end
        else if (c >= 8'd224 && c < 8'd240 && nf >= 3'd2 && cont1 && cont2)
        begin
            res.em[0] = c;
            res.em[1] = b1;
            res.em[2] = b2;
            res.ne    = 2'd3;
            res.used  = 2'd3;
        end
        else if (c >= 8'd240 && c < 8'd245 && nf >= 3'd3)
        begin
            res.ne = 2'd0;
        end
        else
        begin
            res.em[0] = us3s_pkg::LeadC3;
            res.em[1] = c - 8'd64;
            res.ne    = 2'd2;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/us3s_out_stage.sv =====
// Output stage: one-byte hold for last-of-run lookahead plus output register.
`default_nettype none
module us3s_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  us3s_pkg::emit_ctl_t   ctl,
    output logic                  ctl_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output us3s_pkg::out_item_t   out_data
);

    logic                hold_valid_reg;
    logic                hold_valid_next;
    logic [7:0]          hold_byte_reg;
    logic                hold_ends_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    us3s_pkg::out_item_t out_data_reg;
    logic                out_free;
    logic                move;

    assign out_free = !out_valid_reg || out_ready;
    assign ctl_ok   = !hold_valid_reg || out_free;
    // held byte leaves when a newer byte arrives or the run closes
    assign move     = hold_valid_reg && out_free && (ctl.push || ctl.close);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (ctl.push && ctl_ok)
            hold_valid_next = 1'b1;
        else if (ctl.close && ctl_ok)
            hold_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && ctl_ok)
        begin
            hold_byte_reg <= ctl.data;
            hold_ends_reg <= ctl.ends;
        end
        if (move)
        begin
            out_data_reg.out_byte    <= hold_byte_reg;
            out_data_reg.last_of_run <= ctl.close;
            out_data_reg.ends_stream <= hold_ends_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for utf8_three_byte_sanitizer: directed table, then random byte streams.
module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } dir_row_t;

    localparam int DirRows  = 24;
    localparam int DrainCyc = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    us3s_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    us3s_pkg::out_item_t out_data;

    // sanitizer model state
    logic [7:0]          win_bytes [4];
    int unsigned         win_fill;
    logic [7:0]          decided_q [$];
    us3s_pkg::out_item_t utf8_expected_q [$];
    logic [7:0]          strm_q [$];

    int src_idle_pct = 29;
    int rcv_idle_pct = 63;
    int errors = 0;
    int items_sent = 0;

    dir_row_t dir_tab [DirRows];

    utf8_three_byte_sanitizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_cont(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic void add_decided(logic [7:0] b);
        decided_q.insert(decided_q.size(), b);
    endfunction

    function automatic void add_stream(logic [7:0] b);
        strm_q.insert(strm_q.size(), b);
    endfunction

    // Decide the window head with nf following bytes known; returns bytes consumed.
    function automatic int unsigned decide_head(int unsigned nf);
        logic [7:0] c;
        c = win_bytes[0];
        if (c < 8'h20)
        begin
            if (c == us3s_pkg::ByteTab || c == us3s_pkg::ByteLf || c == us3s_pkg::ByteCr)
                add_decided(c);
            return 1;
        end
        if (c < 8'h7F)
        begin
            add_decided(c);
            return 1;
        end
        if (c < 8'hA0)
        begin
            if (c == us3s_pkg::ByteEuro)
            begin
                add_decided(us3s_pkg::EuroB0);
                add_decided(us3s_pkg::EuroB1);
                add_decided(us3s_pkg::EuroB2);
            end
            else if (c == us3s_pkg::ByteNel)
            begin
                add_decided(us3s_pkg::ByteLf);
                add_decided(us3s_pkg::ByteCr);
            end
            return 1;
        end
        if (c < 8'hC0)
        begin
            add_decided(us3s_pkg::LeadC2);
            add_decided(c);
            return 1;
        end
        if (c >= 8'hC2 && c < 8'hE0 && nf >= 1 && is_cont(win_bytes[1]))
        begin
            // overlong-looking C2 with a C1 control behind it is dropped whole
            if (!(c == us3s_pkg::LeadC2 && win_bytes[1] < 8'hA0))
            begin
                add_decided(c);
                add_decided(win_bytes[1]);
            end
            return 2;
        end
        if (c >= 8'hE0 && c < 8'hF0 && nf >= 2 && is_cont(win_bytes[1])
                && is_cont(win_bytes[2]))
        begin
            add_decided(c);
            add_decided(win_bytes[1]);
            add_decided(win_bytes[2]);
            return 3;
        end
        if (c >= 8'hF0 && c < 8'hF5 && nf >= 3)
            return 1;
        add_decided(us3s_pkg::LeadC3);
        add_decided(c - 8'h40);
        return 1;
    endfunction

    function automatic void drop_front(int unsigned n);
        int unsigned k;
        k = (n > win_fill) ? win_fill : n;
        for (int i = 0; i < 4; i++)
            win_bytes[i] = (i + k < 4) ? win_bytes[i + k] : 8'h00;
        win_fill = win_fill - k;
    endfunction

    // Advance the model by one input byte; bytes it causes land in decided_q.
    function automatic void sanitize_byte(us3s_pkg::in_item_t it);
        int unsigned used;
        decided_q.delete();
        if (win_fill >= 4)
            win_fill = 3;
        win_bytes[win_fill] = it.data_byte;
        win_fill++;
        if (it.is_last)
        begin
            while (win_fill > 0)
            begin
                used = decide_head(win_fill - 1);
                drop_front(used);
            end
        end
        else if (win_fill == 4)
        begin
            used = decide_head(3);
            drop_front(used);
        end
    endfunction

    task automatic report(string what, us3s_pkg::out_item_t want, us3s_pkg::out_item_t got);
        errors++;
        if (errors <= 10)
            $display("mismatch (%s): want byte=%h lor=%b end=%b, got byte=%h lor=%b end=%b",
                     what, want.out_byte, want.last_of_run, want.ends_stream,
                     got.out_byte, got.last_of_run, got.ends_stream);
    endtask

    // Queue expectations from decided_q, then offer the transaction.
    task automatic send_item(us3s_pkg::in_item_t it);
        us3s_pkg::out_item_t r;
        for (int i = 0; i < decided_q.size(); i++)
        begin
            r.out_byte    = decided_q[i];
            r.last_of_run = (i == decided_q.size() - 1);
            r.ends_stream = it.is_last;
            utf8_expected_q.insert(utf8_expected_q.size(), r);
        end
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Random byte strings, mostly well-formed UTF-8 tokens mixed with Latin-1,
    // controls and broken sequences; every string ends with is_last.
    task automatic run_phase(int src_pct, int rcv_pct, int n_items);
        us3s_pkg::in_item_t it;
        int                 stop_at;
        int                 ntok;
        int                 kind;
        stop_at = items_sent + n_items;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        while (items_sent < stop_at)
        begin
            strm_q.delete();
            if ($urandom_range(3) == 0)
            begin
                ntok = $urandom_range(1, 10);
                repeat (ntok) add_stream(8'($urandom_range(255)));
            end
            else
            begin
                ntok = $urandom_range(1, 6);
                repeat (ntok)
                begin
                    kind = $urandom_range(9);
                    case (kind)
                        0: add_stream(8'($urandom_range(8'h20, 8'h7E)));
                        1:
                        begin
                            case ($urandom_range(3))
                                0: add_stream(us3s_pkg::ByteTab);
                                1: add_stream(us3s_pkg::ByteLf);
                                2: add_stream(us3s_pkg::ByteCr);
                                default: add_stream(8'($urandom_range(8'h00, 8'h1F)));
                            endcase
                        end
                        2:
                        begin
                            case ($urandom_range(2))
                                0: add_stream(us3s_pkg::ByteEuro);
                                1: add_stream(us3s_pkg::ByteNel);
                                default: add_stream(8'($urandom_range(8'h7F, 8'h9F)));
                            endcase
                        end
                        3: add_stream(8'($urandom_range(8'hA0, 8'hFF)));
                        4:
                        begin
                            add_stream(8'($urandom_range(8'hC2, 8'hDF)));
                            add_stream(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        5:
                        begin
                            add_stream(8'($urandom_range(8'hE0, 8'hEF)));
                            add_stream(8'($urandom_range(8'h80, 8'hBF)));
                            add_stream(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        6:
                        begin
                            add_stream(8'($urandom_range(8'hF0, 8'hF4)));
                            repeat (3) add_stream(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        7:
                        begin
                            // truncated or broken multi-byte sequence
                            add_stream(8'($urandom_range(8'hC0, 8'hFF)));
                            if ($urandom_range(1))
                                add_stream(8'($urandom_range(8'h80, 8'hBF)));
                            if ($urandom_range(1))
                                add_stream(8'($urandom_range(8'h20, 8'h7E)));
                        end
                        default: add_stream(8'($urandom_range(255)));
                    endcase
                end
            end
            for (int i = 0; i < strm_q.size(); i++)
            begin
                it.data_byte = strm_q[i];
                it.is_last   = (i == strm_q.size() - 1);
                sanitize_byte(it);
                send_item(it);
            end
        end
    endtask

    // Output side: check each accepted transaction, then pick next ready.
    always @(posedge clk)
    begin
        us3s_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (utf8_expected_q.size() == 0)
                begin
                    report("unexpected", '0, out_data);
                end
                else
                begin
                    want = utf8_expected_q.pop_front();
                    if (out_data !== want)
                        report("field", want, out_data);
                end
            end
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        us3s_pkg::in_item_t it;
        int unsigned        wait_cyc;

        //                  byte   last  typed n    e0     e1     e2
        dir_tab[0]  = {8'h00, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00};
        dir_tab[1]  = {8'hFF, 1'b1, 1'b1, 2'd2, 8'hC3, 8'hBF, 8'h00};
        dir_tab[2]  = {8'h80, 1'b1, 1'b1, 2'd3, 8'hE2, 8'h82, 8'hAC};
        dir_tab[3]  = {8'h85, 1'b1, 1'b1, 2'd2, 8'h0A, 8'h0D, 8'h00};
        dir_tab[4]  = {8'h09, 1'b1, 1'b1, 2'd1, 8'h09, 8'h00, 8'h00};
        dir_tab[5]  = {8'h7F, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00};
        dir_tab[6]  = {8'hA0, 1'b1, 1'b1, 2'd2, 8'hC2, 8'hA0, 8'h00};
        dir_tab[7]  = {8'hC0, 1'b1, 1'b1, 2'd2, 8'hC3, 8'h80, 8'h00};
        dir_tab[8]  = {8'h7E, 1'b1, 1'b1, 2'd1, 8'h7E, 8'h00, 8'h00};
        // C2 with C1 continuation (dropped), then 2-, 3- and 4-byte sequences
        dir_tab[9]  = {8'hC2, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[10] = {8'h80, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[11] = {8'hDF, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[12] = {8'hBF, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[13] = {8'hE0, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[14] = {8'h80, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[15] = {8'h80, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[16] = {8'hF0, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[17] = {8'h9F, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[18] = {8'h98, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[19] = {8'h80, 1'b0, 1'b0, 2'd0, 24'h0};
        // bad continuation, then a four-byte lead cut short by the flush
        dir_tab[20] = {8'hE1, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[21] = {8'h41, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[22] = {8'hF4, 1'b0, 1'b0, 2'd0, 24'h0};
        dir_tab[23] = {8'h0D, 1'b1, 1'b0, 2'd0, 24'h0};

        for (int i = 0; i < 4; i++)
            win_bytes[i] = 8'h00;
        win_fill = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DirRows; r++)
        begin
            it.data_byte = dir_tab[r].data;
            it.is_last   = dir_tab[r].last;
            sanitize_byte(it);
            if (dir_tab[r].typed)
            begin
                decided_q.delete();
                if (dir_tab[r].n > 0) add_decided(dir_tab[r].e0);
                if (dir_tab[r].n > 1) add_decided(dir_tab[r].e1);
                if (dir_tab[r].n > 2) add_decided(dir_tab[r].e2);
            end
            send_item(it);
        end

        run_phase(29, 63, 145);
        run_phase(63, 29, 145);
        run_phase(0, 0, 145);
        in_valid <= 1'b0;

        wait_cyc = 0;
        while (utf8_expected_q.size() != 0 && wait_cyc < 20000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        if (utf8_expected_q.size() != 0)
        begin
            errors++;
            $display("%0d expected transactions never arrived", utf8_expected_q.size());
        end
        repeat (DrainCyc) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
